/* rtl/sveg_pkg.sv */
package sveg_pkg;

  localparam int FUNC_W   = 3;
  localparam int TARGET_W = 10;
  localparam int RFRAC_W  = 16;
  localparam int MEAS_W   = 10;
  localparam int QC_W     = 4;

  localparam logic [QC_W-1:0] QC_RESET = 4'd2;

  // 1/sqrt2 in 0.24 fixed point
  localparam logic [23:0] INV_SQRT2_Q24 = 24'd11863283;
  localparam int          K_SHIFT       = 24;

  typedef enum logic [FUNC_W-1:0] {
    FN_RESET     = 3'd0,
    FN_HADAMARD  = 3'd1,
    FN_ORACLE    = 3'd2,
    FN_DIFFUSION = 3'd3,
    FN_MEASURE   = 3'd4
  } func_e;

endpackage

/* rtl/sveg_ifs.sv */
interface sveg_req_if;
  logic                           valid;
  logic                           ready;
  logic [sveg_pkg::FUNC_W-1:0]    func;
  logic [sveg_pkg::TARGET_W-1:0]  target;
  logic [sveg_pkg::RFRAC_W-1:0]   random_fraction;

  modport source (output valid, func, target, random_fraction, input ready);
  modport sink (input valid, func, target, random_fraction, output ready);
endinterface

interface sveg_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sveg_pkg::MEAS_W-1:0]  measured_state;
  logic                         measurement_valid;
  logic                         target_error;

  modport source (output valid, measured_state, measurement_valid, target_error,
                  input ready);
  modport sink (input valid, measured_state, measurement_valid, target_error,
                output ready);
endinterface

interface sveg_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sveg_pkg::QC_W-1:0]  qubit_count;

  modport source (output valid, qubit_count, input ready);
  modport sink (input valid, qubit_count, output ready);
endinterface

/* rtl/sveg_ram.sv */
module sveg_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/state_vector_gate_engine_top.sv */
// State-vector gate engine: 2^n real amplitudes (signed, AMP_WIDTH bits, two integer
// bits) live in one single-port-write, single-port-read ram with a registered read, and
// a sequencer walks it for each operation. After reset a clearing pass over all
// 2^MAX_QUBITS entries loads basis state zero and no operation is taken meanwhile;
// the reset operation repeats that pass. Hadamard reads and rewrites each pair and
// skips indices with the target bit set, oracle reads and rewrites one entry,
// diffusion makes two streaming sweeps, and measure makes one streaming sweep that
// stops at the pick.
// One operation is worked on at a time; each gives exactly one result transfer,
// and the next operation is taken while a result waits in the output register.
module state_vector_gate_engine_top #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH  = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sveg_req_if.sink   req_i,
  sveg_rsp_if.source rsp_o,
  sveg_cfg_if.sink   cfg_i
);

  localparam int AW    = MAX_QUBITS;
  localparam int DEPTH = 1 << MAX_QUBITS;
  localparam int FRAC  = AMP_WIDTH - 2;
  localparam int NW    = $clog2(MAX_QUBITS + 1);
  localparam int SUMW  = AMP_WIDTH + MAX_QUBITS + 1;
  localparam int PW    = AMP_WIDTH + 1 + 26;
  localparam int SQW   = 2 * AMP_WIDTH;
  localparam int CUMW  = 2 * AMP_WIDTH + MAX_QUBITS;
  localparam int RSH   = 2 * FRAC - sveg_pkg::RFRAC_W;

  localparam logic signed [63:0] AMP_MAX = (64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] AMP_MIN = -AMP_MAX - 64'sd1;
  localparam logic [AMP_WIDTH-1:0] AMP_ONE = AMP_WIDTH'(1) << FRAC;
  localparam logic signed [25:0] K_Q24 = signed'({2'b00, sveg_pkg::INV_SQRT2_Q24});
  localparam logic signed [63:0] K_HALF = 64'sd1 <<< (sveg_pkg::K_SHIFT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_H_RDA, ST_H_RDB, ST_H_ADD, ST_H_MUL, ST_H_WLO, ST_H_WHI,
    ST_O_RD, ST_O_WR, ST_D_SUM, ST_D_MEAN, ST_D_WR, ST_M_RUN, ST_DONE
  } state_e;

  function automatic logic [AMP_WIDTH-1:0] sat(input logic signed [63:0] v);
    logic [AMP_WIDTH-1:0] r;
    if (v > AMP_MAX) r = AMP_MAX[AMP_WIDTH-1:0];
    else if (v < AMP_MIN) r = AMP_MIN[AMP_WIDTH-1:0];
    else r = v[AMP_WIDTH-1:0];
    return r;
  endfunction

  state_e state_q;

  // operation and config registers
  logic [sveg_pkg::QC_W-1:0]     qc_q;
  logic [sveg_pkg::TARGET_W-1:0] target_q;
  logic [sveg_pkg::RFRAC_W-1:0]  rfrac_q;
  logic                          clr_rsp_q;

  // sweep control
  logic [AW:0]   cnt_q;
  logic          rd_vld_q, sq_vld_q, found_q;
  logic [AW-1:0] idx_q, idx2_q, pick_q;

  // datapath registers
  logic signed [AMP_WIDTH-1:0] a_q;
  logic signed [AMP_WIDTH:0]   sum_q, dif_q;
  logic signed [PW-1:0]        plo_q, phi_q;
  logic signed [SUMW-1:0]      acc_q, mean_q;
  logic [SQW-1:0]              sq_q;
  logic [CUMW-1:0]             cum_q;

  // pending and output result
  logic [sveg_pkg::MEAS_W-1:0] meas_q, out_meas_q;
  logic                        mval_q, terr_q;
  logic                        out_vld_q, out_mval_q, out_terr_q;

  // active size
  logic [NW-1:0] n_act;
  logic [AW:0]   size;
  logic [AW-1:0] lo_addr, bitmask;
  logic          issue;

  // ram port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [AMP_WIDTH-1:0] ram_wdata, ram_rdata;

  logic signed [63:0] rnd_lo, rnd_hi, diff_val, neg_val;
  logic [CUMW-1:0]    cum_next, r_scaled;
  logic signed [SQW-1:0] sq_s;

  always_comb begin
    if (qc_q == '0) n_act = NW'(1);
    else if (32'(qc_q) > MAX_QUBITS) n_act = NW'(MAX_QUBITS);
    else n_act = NW'(qc_q);
  end

  assign size     = (AW + 1)'(1) << n_act;
  assign lo_addr  = cnt_q[AW-1:0];
  assign bitmask  = AW'(1) << target_q;
  assign issue    = (cnt_q < size) && !found_q;

  assign rnd_lo   = (64'(plo_q) + K_HALF) >>> sveg_pkg::K_SHIFT;
  assign rnd_hi   = (64'(phi_q) + K_HALF) >>> sveg_pkg::K_SHIFT;
  assign diff_val = (64'(mean_q) <<< 1) - 64'(signed'(ram_rdata));
  assign neg_val  = -64'(signed'(ram_rdata));
  assign sq_s     = signed'(ram_rdata) * signed'(ram_rdata);
  assign cum_next = cum_q + CUMW'(sq_q);
  assign r_scaled = CUMW'(rfrac_q) << RSH;

  // ram read and write controls follow the sequencer state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo_addr;
    ram_wdata = '0;
    ram_raddr = lo_addr;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (lo_addr == '0) ? AMP_ONE : '0;
      end
      ST_H_RDB: ram_raddr = lo_addr | bitmask;
      ST_H_WLO: begin
        ram_we    = 1'b1;
        ram_wdata = sat(rnd_lo);
      end
      ST_H_WHI: begin
        ram_we    = 1'b1;
        ram_waddr = lo_addr | bitmask;
        ram_wdata = sat(rnd_hi);
      end
      ST_O_RD: ram_raddr = AW'(target_q);
      ST_O_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(target_q);
        ram_wdata = sat(neg_val);
      end
      ST_D_WR: begin
        ram_we    = rd_vld_q;
        ram_waddr = idx_q;
        ram_wdata = sat(diff_val);
      end
      default: ;
    endcase
  end

  sveg_ram #(
    .WIDTH (AMP_WIDTH),
    .DEPTH (DEPTH)
  ) u_amp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid             = out_vld_q;
  assign rsp_o.measured_state    = out_meas_q;
  assign rsp_o.measurement_valid = out_mval_q;
  assign rsp_o.target_error      = out_terr_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q <= sveg_pkg::QC_RESET;
    end else if (cfg_i.valid) begin
      qc_q <= cfg_i.qubit_count;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      clr_rsp_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      sq_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      out_meas_q <= '0;
      out_mval_q <= 1'b0;
      out_terr_q <= 1'b0;
    end else begin
      rd_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
      if (out_vld_q && rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (lo_addr == '1) begin
            cnt_q   <= '0;
            state_q <= clr_rsp_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_i.valid) begin
            target_q  <= req_i.target;
            rfrac_q   <= req_i.random_fraction;
            meas_q    <= '0;
            mval_q    <= 1'b0;
            terr_q    <= 1'b0;
            cnt_q     <= '0;
            acc_q     <= '0;
            cum_q     <= '0;
            found_q   <= 1'b0;
            clr_rsp_q <= 1'b0;
            case (req_i.func)
              sveg_pkg::FN_RESET: begin
                clr_rsp_q <= 1'b1;
                state_q   <= ST_CLEAR;
              end
              sveg_pkg::FN_HADAMARD: begin
                if (req_i.target >= sveg_pkg::TARGET_W'(n_act)) begin
                  terr_q  <= 1'b1;
                  state_q <= ST_DONE;
                end else begin
                  state_q <= ST_H_RDA;
                end
              end
              sveg_pkg::FN_ORACLE: begin
                if (32'(req_i.target) >= 32'(size)) begin
                  terr_q  <= 1'b1;
                  state_q <= ST_DONE;
                end else begin
                  state_q <= ST_O_RD;
                end
              end
              sveg_pkg::FN_DIFFUSION: state_q <= ST_D_SUM;
              sveg_pkg::FN_MEASURE:   state_q <= ST_M_RUN;
              default:                state_q <= ST_DONE;
            endcase
          end
        end
        // hadamard: low entry read here, skip indices with the target bit set
        ST_H_RDA: begin
          if (cnt_q == size) begin
            state_q <= ST_DONE;
          end else if ((lo_addr & bitmask) != '0) begin
            cnt_q <= cnt_q + 1'b1;
          end else begin
            state_q <= ST_H_RDB;
          end
        end
        ST_H_RDB: begin
          a_q     <= signed'(ram_rdata);
          state_q <= ST_H_ADD;
        end
        ST_H_ADD: begin
          sum_q   <= (AMP_WIDTH + 1)'(a_q) + (AMP_WIDTH + 1)'(signed'(ram_rdata));
          dif_q   <= (AMP_WIDTH + 1)'(a_q) - (AMP_WIDTH + 1)'(signed'(ram_rdata));
          state_q <= ST_H_MUL;
        end
        ST_H_MUL: begin
          plo_q   <= PW'(sum_q * K_Q24);
          phi_q   <= PW'(dif_q * K_Q24);
          state_q <= ST_H_WLO;
        end
        ST_H_WLO: state_q <= ST_H_WHI;
        ST_H_WHI: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= ST_H_RDA;
        end
        ST_O_RD: state_q <= ST_O_WR;
        ST_O_WR: state_q <= ST_DONE;
        // diffusion sum sweep
        ST_D_SUM: begin
          if (cnt_q < size) begin
            cnt_q    <= cnt_q + 1'b1;
            rd_vld_q <= 1'b1;
          end
          if (rd_vld_q) begin
            acc_q <= acc_q + SUMW'(signed'(ram_rdata));
          end
          if (cnt_q == size && !rd_vld_q) begin
            state_q <= ST_D_MEAN;
          end
        end
        ST_D_MEAN: begin
          mean_q  <= acc_q >>> n_act;
          cnt_q   <= '0;
          state_q <= ST_D_WR;
        end
        // diffusion rewrite sweep: write entry i while reading i + 1
        ST_D_WR: begin
          if (cnt_q < size) begin
            cnt_q    <= cnt_q + 1'b1;
            rd_vld_q <= 1'b1;
            idx_q    <= lo_addr;
          end
          if (cnt_q == size && !rd_vld_q) begin
            state_q <= ST_DONE;
          end
        end
        // measure: read, square, accumulate and compare
        ST_M_RUN: begin
          if (issue) begin
            cnt_q    <= cnt_q + 1'b1;
            rd_vld_q <= 1'b1;
            idx_q    <= lo_addr;
          end
          if (rd_vld_q) begin
            sq_q     <= unsigned'(sq_s);
            sq_vld_q <= 1'b1;
            idx2_q   <= idx_q;
          end
          if (sq_vld_q && !found_q) begin
            cum_q <= cum_next;
            if (r_scaled <= cum_next) begin
              found_q <= 1'b1;
              pick_q  <= idx2_q;
            end
          end
          if (found_q) begin
            meas_q  <= sveg_pkg::MEAS_W'(pick_q);
            mval_q  <= 1'b1;
            state_q <= ST_DONE;
          end else if (cnt_q == size && !rd_vld_q && !sq_vld_q) begin
            meas_q  <= sveg_pkg::MEAS_W'(size - 1'b1);
            mval_q  <= 1'b1;
            state_q <= ST_DONE;
          end
        end
        // hand the result to the output register once it is free
        ST_DONE: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q  <= 1'b1;
            out_meas_q <= meas_q;
            out_mval_q <= mval_q;
            out_terr_q <= terr_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // no store write while waiting for an operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !ram_we)
    else $error("store written while idle");

  // a measurement never carries a target error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.measurement_valid |-> !rsp_o.target_error)
    else $error("measurement flagged with target error");

  // every accepted operation leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q != ST_IDLE)
    else $error("operation accepted without starting");

  // each diffusion read returns into a write of the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_D_WR && rd_vld_q |-> ram_we && ram_waddr == idx_q)
    else $error("diffusion rewrite lost");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int NQ_MAX   = 10;
  localparam int AMP_W    = 18;
  localparam int FRAC_B   = AMP_W - 2;
  localparam int DEPTH    = 1 << NQ_MAX;
  localparam int N_RANDOM = 270;
  localparam int HOLD_CYC = 10000;

  typedef struct packed {
    logic [sveg_pkg::MEAS_W-1:0] state;
    logic                        meas_vld;
    logic                        tgt_err;
  } outcome_t;

  typedef struct {
    sveg_pkg::func_e               fn;
    logic [sveg_pkg::TARGET_W-1:0] tgt;
    logic [sveg_pkg::RFRAC_W-1:0]  frac;
    logic                          has_exp;
    outcome_t                      exp_out;
  } op_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sveg_req_if req_if ();
  sveg_rsp_if rsp_if ();
  sveg_cfg_if cfg_if ();

  state_vector_gate_engine_top #(.MAX_QUBITS(NQ_MAX), .AMP_WIDTH(AMP_W)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the amplitude store and the qubit count register
  longint    amp_q[DEPTH];
  logic [3:0] qc_q;
  outcome_t  outcome_q[$];
  int        err_cnt = 0;
  int        rsp_cnt = 0;
  bit        hold_long = 1'b0;

  function automatic longint clip_amp(longint v);
    longint hi;
    hi = (longint'(1) <<< (AMP_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // (a +- b) * 1/sqrt2, round half up; >>> on signed longint floors
  function automatic longint scale_k(longint v);
    return (v * longint'(sveg_pkg::INV_SQRT2_Q24) +
            (longint'(1) <<< (sveg_pkg::K_SHIFT - 1))) >>> sveg_pkg::K_SHIFT;
  endfunction

  function automatic int live_qubits();
    if (qc_q == 0) return 1;
    if (qc_q > NQ_MAX) return NQ_MAX;
    return qc_q;
  endfunction

  function automatic void load_ground();
    foreach (amp_q[i]) amp_q[i] = 0;
    amp_q[0] = longint'(1) <<< FRAC_B;
  endfunction

  // applies one operation to the shadow store and returns its outcome
  function automatic outcome_t apply_gate(logic [2:0] fn,
                                          logic [sveg_pkg::TARGET_W-1:0] tgt,
                                          logic [sveg_pkg::RFRAC_W-1:0] frac);
    outcome_t o;
    int n;
    int size;
    int bitm;
    longint a, b, sum, mean;
    longint unsigned r, cum, m;
    n = live_qubits();
    size = 1 << n;
    o = '0;
    case (fn)
      sveg_pkg::FN_RESET: load_ground();
      sveg_pkg::FN_HADAMARD: begin
        if (tgt >= n) begin
          o.tgt_err = 1'b1;
        end else begin
          bitm = 1 << tgt;
          for (int i = 0; i < size; i++) begin
            if ((i & bitm) == 0) begin
              a = amp_q[i];
              b = amp_q[i | bitm];
              amp_q[i] = clip_amp(scale_k(a + b));
              amp_q[i | bitm] = clip_amp(scale_k(a - b));
            end
          end
        end
      end
      sveg_pkg::FN_ORACLE: begin
        if (tgt >= size) o.tgt_err = 1'b1;
        else amp_q[tgt] = clip_amp(-amp_q[tgt]);
      end
      sveg_pkg::FN_DIFFUSION: begin
        sum = 0;
        for (int i = 0; i < size; i++) sum += amp_q[i];
        mean = sum >>> n;
        for (int i = 0; i < size; i++) amp_q[i] = clip_amp(2 * mean - amp_q[i]);
      end
      sveg_pkg::FN_MEASURE: begin
        r = longint'(frac) << (2 * FRAC_B - 16);
        cum = 0;
        o.state = sveg_pkg::MEAS_W'(size - 1);
        for (int i = 0; i < size; i++) begin
          m = amp_q[i] < 0 ? -amp_q[i] : amp_q[i];
          cum += m * m;
          if (r <= cum) begin
            o.state = sveg_pkg::MEAS_W'(i);
            break;
          end
        end
        o.meas_vld = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  // random gap length: mostly none or short, a few long
  function automatic int gap_len();
    int g;
    g = $urandom_range(0, 99);
    if (g < 50) g = 0;
    else if (g < 95) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    return g;
  endfunction

  // request side gap: valid drops only when a gap is taken
  task automatic req_idle();
    int g;
    g = gap_len();
    if (g != 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // one request transfer; the expectation is either typed in or predicted
  task automatic drive_req(logic [2:0] fn, logic [sveg_pkg::TARGET_W-1:0] tgt,
                           logic [sveg_pkg::RFRAC_W-1:0] frac, bit he, outcome_t eo);
    outcome_t p;
    req_if.valid           <= 1'b1;
    req_if.func            <= fn;
    req_if.target          <= tgt;
    req_if.random_fraction <= frac;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    p = apply_gate(fn, tgt, frac);
    outcome_q.push_back(he ? eo : p);
  endtask

  task automatic send_op(sveg_pkg::func_e fn, logic [sveg_pkg::TARGET_W-1:0] tgt,
                         logic [sveg_pkg::RFRAC_W-1:0] frac);
    drive_req(fn, tgt, frac, 1'b0, '0);
  endtask

  // raw func code, including the unused ones
  task automatic send_raw(logic [2:0] fn, logic [sveg_pkg::TARGET_W-1:0] tgt,
                          logic [sveg_pkg::RFRAC_W-1:0] frac);
    drive_req(fn, tgt, frac, 1'b0, '0);
  endtask

  // register write only once the engine has drained
  task automatic write_qubits(logic [3:0] v);
    req_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (3 * DEPTH + 20) @(posedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.qubit_count <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    qc_q = v;
  endtask

  // response side: random stalls plus one long hold-off
  initial begin
    int g;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_long = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g != 0) begin
          rsp_if.ready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin
    outcome_t got, exp_o;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.state    = rsp_if.measured_state;
      got.meas_vld = rsp_if.measurement_valid;
      got.tgt_err  = rsp_if.target_error;
      rsp_cnt++;
      if (outcome_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result transfer %0d: %p", rsp_cnt, got);
      end else begin
        exp_o = outcome_q.pop_front();
        if (got !== exp_o) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result %0d mismatch: exp state=%0d mv=%0b err=%0b got state=%0d mv=%0b err=%0b",
                     rsp_cnt, exp_o.state, exp_o.meas_vld, exp_o.tgt_err,
                     got.state, got.meas_vld, got.tgt_err);
        end
      end
    end
  end

  // directed table: expected outcome typed in where obvious, else from the predictor
  op_row_t dir_rows[$];

  task automatic add_row(sveg_pkg::func_e fn, int tgt, int frac, bit he, outcome_t eo);
    op_row_t r;
    r.fn = fn;
    r.tgt = sveg_pkg::TARGET_W'(tgt);
    r.frac = sveg_pkg::RFRAC_W'(frac);
    r.has_exp = he;
    r.exp_out = eo;
    dir_rows.push_back(r);
  endtask

  // random sequences: mostly Grover-like rounds with random content
  task automatic random_op();
    int n, k;
    logic [sveg_pkg::TARGET_W-1:0] tgt;
    logic [sveg_pkg::RFRAC_W-1:0]  frac;
    n = live_qubits();
    k = $urandom_range(0, 99);
    tgt = sveg_pkg::TARGET_W'($urandom);
    frac = sveg_pkg::RFRAC_W'($urandom);
    if (k < 10) begin
      send_op(sveg_pkg::FN_RESET, tgt, frac);
    end else if (k < 40) begin
      if ($urandom_range(0, 9) < 8) tgt = sveg_pkg::TARGET_W'($urandom_range(0, n - 1));
      send_op(sveg_pkg::FN_HADAMARD, tgt, frac);
    end else if (k < 55) begin
      if ($urandom_range(0, 9) < 8)
        tgt = sveg_pkg::TARGET_W'($urandom_range(0, (1 << n) - 1));
      send_op(sveg_pkg::FN_ORACLE, tgt, frac);
    end else if (k < 70) begin
      send_op(sveg_pkg::FN_DIFFUSION, tgt, frac);
    end else if (k < 95) begin
      send_op(sveg_pkg::FN_MEASURE, tgt, frac);
    end else begin
      send_raw(3'($urandom_range(5, 7)), tgt, frac);
    end
  endtask

  initial begin
    logic [3:0] qc_list[6];
    outcome_t eo;
    qc_list = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd3, 4'd4};
    req_if.valid           <= 1'b0;
    req_if.func            <= sveg_pkg::FN_RESET;
    req_if.target          <= '0;
    req_if.random_fraction <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.qubit_count     <= '0;
    qc_q = sveg_pkg::QC_RESET;
    load_ground();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // after reset: measure of ground state gives 0, bad targets flagged
    eo = '0; eo.meas_vld = 1'b1;
    add_row(sveg_pkg::FN_MEASURE, 0, 16'hFFFF, 1, eo);
    eo = '0; eo.tgt_err = 1'b1;
    add_row(sveg_pkg::FN_HADAMARD, 2, 0, 1, eo);
    add_row(sveg_pkg::FN_HADAMARD, 1023, 0, 1, eo);
    add_row(sveg_pkg::FN_ORACLE, 4, 0, 1, eo);
    add_row(sveg_pkg::FN_ORACLE, 1023, 16'hFFFF, 1, eo);
    eo = '0;
    add_row(sveg_pkg::FN_HADAMARD, 0, 0, 0, eo);
    add_row(sveg_pkg::FN_HADAMARD, 1, 0, 0, eo);
    add_row(sveg_pkg::FN_ORACLE, 3, 0, 0, eo);
    add_row(sveg_pkg::FN_DIFFUSION, 0, 0, 0, eo);
    add_row(sveg_pkg::FN_MEASURE, 0, 0, 0, eo);
    add_row(sveg_pkg::FN_MEASURE, 0, 16'h8000, 0, eo);
    add_row(sveg_pkg::FN_MEASURE, 0, 16'hFFFF, 0, eo);
    add_row(sveg_pkg::FN_DIFFUSION, 0, 0, 0, eo);
    add_row(sveg_pkg::FN_DIFFUSION, 0, 0, 0, eo);
    add_row(sveg_pkg::FN_ORACLE, 0, 0, 0, eo);
    add_row(sveg_pkg::FN_RESET, 0, 0, 1, eo);
    add_row(sveg_pkg::FN_ORACLE, 0, 0, 0, eo);
    add_row(sveg_pkg::FN_HADAMARD, 0, 16'h5555, 0, eo);
    add_row(sveg_pkg::FN_MEASURE, 0, 16'hAAAA, 0, eo);

    foreach (dir_rows[i]) begin
      drive_req(dir_rows[i].fn, dir_rows[i].tgt, dir_rows[i].frac,
                dir_rows[i].has_exp, dir_rows[i].exp_out);
      req_idle();
    end
    // unused func codes give an all-zero result
    send_raw(3'd5, 10'h3FF, 16'hFFFF);
    req_idle();
    send_raw(3'd7, 10'h000, 16'h0000);

    // random phases over several qubit counts, extremes included
    foreach (qc_list[p]) begin
      write_qubits(qc_list[p]);
      if (p == 1) hold_long = 1'b1;
      for (int j = 0; j < N_RANDOM / 6; j++) begin
        random_op();
        // with ten qubits keep the back-to-back stream dense for the hold-off
        if (!(p == 1 && j < 20)) req_idle();
      end
    end

    req_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (3 * DEPTH + 20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
rtl/sveg_pkg.sv
rtl/sveg_ifs.sv
rtl/sveg_ram.sv
rtl/state_vector_gate_engine_top.sv
tb/tb_top.sv
